>>> rtl/lsfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared constants, mode codes and request/result types of the LED string
// fade engine.
// ----------------------------------------------------------------------------
package lsfe_pkg;

    localparam int MAX_LEDS   = 64;
    localparam int LED_IDX_W  = 6;
    localparam int LED_CNT_W  = 7;
    localparam int COLOUR_W   = 32;
    localparam int TICK_W     = 8;
    localparam int NUM_W      = 16;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_FADE   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [COLOUR_W-1:0] colour_word;
        logic [TICK_W-1:0]   fade_steps;
        logic                last_in_batch;
    } lsfe_in_t;

    typedef struct packed {
        logic [LED_IDX_W-1:0] led_position;
        logic [COLOUR_W-1:0]  shown_colour;
        logic                 last_led;
    } lsfe_out_t;

endpackage : lsfe_pkg
`default_nettype wire

>>> rtl/lsfe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_div
// Restoring serial divider, one quotient bit per cycle, for the fade portion.
// ----------------------------------------------------------------------------
module lsfe_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [lsfe_pkg::NUM_W-1:0]  dividend,
    input  wire logic [lsfe_pkg::TICK_W-1:0] divisor,
    output logic                           done,
    output logic [lsfe_pkg::NUM_W-1:0]     quotient
);
    import lsfe_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [TICK_W-1:0] den_reg, den_next;
    logic [TICK_W:0]   shifted;
    logic [TICK_W:0]   trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end else if (cnt_reg != '0) begin
            // keep the trial difference when it does not go negative
            if (!trial[TICK_W]) begin
                rem_next = trial[TICK_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[TICK_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : lsfe_div
`default_nettype wire

>>> rtl/lsfe_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_blend
// Four-byte linear blend: source + trunc((target - source) * portion / 255).
// Product registered, divide by 255 and final add on the next cycle.
// ----------------------------------------------------------------------------
module lsfe_blend (
    input  wire logic                        aclk,
    input  wire logic                        load,
    input  wire logic [lsfe_pkg::COLOUR_W-1:0] src_word,
    input  wire logic [lsfe_pkg::COLOUR_W-1:0] tgt_word,
    input  wire logic [lsfe_pkg::TICK_W-1:0]   portion,
    output logic [lsfe_pkg::COLOUR_W-1:0]    result_word
);
    import lsfe_pkg::*;

    localparam int LANES = COLOUR_W / 8;

    logic [15:0] prod_reg [LANES];
    logic        neg_reg  [LANES];
    logic [7:0]  src_reg  [LANES];

    // exact x / 255 for any x up to 255 * 255, the largest product here
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int l = 0; l < LANES; l++) begin
                logic [7:0] s;
                logic [7:0] t;
                logic [7:0] mag;
                s   = src_word[8*l +: 8];
                t   = tgt_word[8*l +: 8];
                mag = (t >= s) ? (t - s) : (s - t);
                prod_reg[l] <= 16'(mag) * 16'(portion);
                neg_reg[l]  <= (t < s);
                src_reg[l]  <= s;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            result_word[8*l +: 8] = neg_reg[l] ? (src_reg[l] - div255(prod_reg[l]))
                                               : (src_reg[l] + div255(prod_reg[l]));
        end
    end

endmodule : lsfe_blend
`default_nettype wire

>>> rtl/led_string_fade_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_string_fade_engine
// Per-LED colour store with direct writes, linear crossfades, clearing and refresh.
//
// Requests enter on s_valid/s_ready; one request at a time. Results leave on
// m_valid/m_ready through an output register, one word per present LED,
// LED 0 first, last_led set on the final one. The user must write the LED
// count through cfg_wr_en/cfg_wr_data only while the engine is idle; the
// block itself does not enforce this. States of a request:
//   direct or fade-target word without last flag: ST_IDLE, then ST_COPY
//   for a fade word; refresh: ST_R_RD then ST_R_LD for each LED.
//   tick: ST_TICK starts the serial portion divider, ST_DIV waits for it,
//   then ST_T_RD, ST_T_MUL and ST_T_WR for each LED through the shared
//   blend unit, then ST_T_END and the refresh.
// A stalled receiver holds the refresh walk at the output register; the
// final word may still wait there while the next request is taken.
// Reset clears all colours, the fade, the write position and the LED count;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module led_string_fade_engine (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lsfe_pkg::LED_CNT_W-1:0]      cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire lsfe_pkg::lsfe_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output lsfe_pkg::lsfe_out_t                      m_data
);
    import lsfe_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_COPY  = 4'd1;
    localparam logic [3:0] ST_TICK  = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_T_RD  = 4'd4;
    localparam logic [3:0] ST_T_MUL = 4'd5;
    localparam logic [3:0] ST_T_WR  = 4'd6;
    localparam logic [3:0] ST_T_END = 4'd7;
    localparam logic [3:0] ST_R_RD  = 4'd8;
    localparam logic [3:0] ST_R_LD  = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [LED_CNT_W-1:0] num_leds_reg, num_leds_next;
    logic [LED_CNT_W-1:0] pos_reg, pos_next;
    logic [LED_CNT_W-1:0] idx_reg, idx_next;
    logic [TICK_W-1:0]    len_reg, len_next;
    logic [TICK_W-1:0]    done_reg, done_next;
    logic [TICK_W-1:0]    portion_reg, portion_next;
    logic                 copy_en_reg, copy_en_next;
    logic [LED_IDX_W-1:0] copy_pos_reg, copy_pos_next;
    logic                 last_reg, last_next;
    logic [TICK_W-1:0]    cycles_reg, cycles_next;
    logic [MAX_LEDS-1:0]  vld_reg, vld_next;
    logic                 m_valid_reg, m_valid_next;
    lsfe_out_t            m_data_reg;
    lsfe_out_t            m_data_next;
    logic                 out_load;

    logic [COLOUR_W-1:0]  cur_mem [MAX_LEDS];
    logic [COLOUR_W-1:0]  src_mem [MAX_LEDS];
    logic [COLOUR_W-1:0]  tgt_mem [MAX_LEDS];
    logic [COLOUR_W-1:0]  cur_rd_reg;
    logic                 cur_rd_vld_reg;
    logic [COLOUR_W-1:0]  src_rd_reg;
    logic [COLOUR_W-1:0]  tgt_rd_reg;

    logic                 cur_we, cur_re, src_we, tgt_we, st_re;
    logic [LED_IDX_W-1:0] cur_waddr, cur_raddr;
    logic [COLOUR_W-1:0]  cur_wdata;
    logic [COLOUR_W-1:0]  cur_rd_word;

    logic [LED_CNT_W-1:0] present;
    logic                 in_range;
    logic [LED_CNT_W-1:0] pos_adv;
    logic [LED_CNT_W-1:0] idx_inc;
    logic                 idx_last;
    logic [TICK_W-1:0]    done_inc;

    logic                 div_start, div_done;
    logic [NUM_W-1:0]     div_num, div_quo;
    logic                 blend_load;
    logic [COLOUR_W-1:0]  blend_word;

    lsfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    lsfe_blend u_blend (
        .aclk        (aclk),
        .load        (blend_load),
        .src_word    (src_rd_reg),
        .tgt_word    (tgt_rd_reg),
        .portion     (portion_reg),
        .result_word (blend_word)
    );

    assign present  = (num_leds_reg > LED_CNT_W'(MAX_LEDS)) ? LED_CNT_W'(MAX_LEDS)
                                                           : num_leds_reg;
    assign in_range = (pos_reg < present);
    assign pos_adv  = (pos_reg < LED_CNT_W'(MAX_LEDS)) ? pos_reg + LED_CNT_W'(1) : pos_reg;
    assign idx_inc  = idx_reg + LED_CNT_W'(1);
    assign idx_last = (idx_inc == present);
    assign done_inc = done_reg + TICK_W'(1);
    // done_inc * 255
    assign div_num  = {done_inc, 8'd0} - {8'd0, done_inc};
    assign cur_rd_word = cur_rd_vld_reg ? cur_rd_reg : '0;

    always_comb begin
        state_next     = state_reg;
        num_leds_next  = num_leds_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        done_next      = done_reg;
        portion_next   = portion_reg;
        copy_en_next   = copy_en_reg;
        copy_pos_next  = copy_pos_reg;
        last_next      = last_reg;
        cycles_next    = cycles_reg;
        vld_next       = vld_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_data_next    = m_data_reg;
        out_load       = 1'b0;
        cur_we         = 1'b0;
        cur_waddr      = idx_reg[LED_IDX_W-1:0];
        cur_wdata      = blend_word;
        cur_re         = 1'b0;
        cur_raddr      = idx_reg[LED_IDX_W-1:0];
        src_we         = 1'b0;
        tgt_we         = 1'b0;
        st_re          = 1'b0;
        div_start      = 1'b0;
        blend_load     = 1'b0;

        if (cfg_wr_en) begin
            num_leds_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.mode)
                        MODE_DIRECT: begin
                            cur_we    = in_range;
                            cur_waddr = pos_reg[LED_IDX_W-1:0];
                            cur_wdata = s_data.colour_word;
                            if (in_range) begin
                                vld_next[pos_reg[LED_IDX_W-1:0]] = 1'b1;
                            end
                            pos_next  = pos_adv;
                            len_next  = '0;
                            done_next = '0;
                            if (s_data.last_in_batch) begin
                                pos_next   = '0;
                                idx_next   = '0;
                                state_next = (present == '0) ? ST_IDLE : ST_R_RD;
                            end
                        end
                        MODE_FADE: begin
                            // read current now, copy it to source next cycle
                            tgt_we        = in_range;
                            cur_re        = in_range;
                            cur_raddr     = pos_reg[LED_IDX_W-1:0];
                            copy_en_next  = in_range;
                            copy_pos_next = pos_reg[LED_IDX_W-1:0];
                            last_next     = s_data.last_in_batch;
                            cycles_next   = s_data.fade_steps;
                            pos_next      = pos_adv;
                            state_next    = ST_COPY;
                        end
                        MODE_TICK: begin
                            if (len_reg != '0) begin
                                state_next = ST_TICK;
                            end
                        end
                        MODE_OFF: begin
                            vld_next   = '0;
                            len_next   = '0;
                            done_next  = '0;
                            pos_next   = '0;
                            idx_next   = '0;
                            state_next = (present == '0) ? ST_IDLE : ST_R_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COPY: begin
                src_we = copy_en_reg;
                if (last_reg) begin
                    pos_next  = '0;
                    len_next  = cycles_reg;
                    done_next = '0;
                    idx_next  = '0;
                    if (cycles_reg == '0) begin
                        state_next = (present == '0) ? ST_IDLE : ST_R_RD;
                    end else begin
                        state_next = ST_TICK;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK: begin
                done_next  = done_inc;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    portion_next = (div_quo > NUM_W'(255)) ? TICK_W'(255)
                                                           : div_quo[TICK_W-1:0];
                    idx_next     = '0;
                    state_next   = (present == '0) ? ST_T_END : ST_T_RD;
                end
            end
            ST_T_RD: begin
                st_re      = 1'b1;
                state_next = ST_T_MUL;
            end
            ST_T_MUL: begin
                blend_load = 1'b1;
                state_next = ST_T_WR;
            end
            ST_T_WR: begin
                cur_we = 1'b1;
                vld_next[idx_reg[LED_IDX_W-1:0]] = 1'b1;
                if (idx_last) begin
                    state_next = ST_T_END;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_T_RD;
                end
            end
            ST_T_END: begin
                // stop the fade once the final tick is in
                if (done_reg >= len_reg) begin
                    len_next  = '0;
                    done_next = '0;
                end
                idx_next   = '0;
                state_next = (present == '0) ? ST_IDLE : ST_R_RD;
            end
            ST_R_RD: begin
                cur_re     = 1'b1;
                state_next = ST_R_LD;
            end
            ST_R_LD: begin
                if (!m_valid_reg || m_ready) begin
                    out_load                 = 1'b1;
                    m_valid_next             = 1'b1;
                    m_data_next.led_position = idx_reg[LED_IDX_W-1:0];
                    m_data_next.shown_colour = cur_rd_word;
                    m_data_next.last_led     = idx_last;
                    if (idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_R_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (cur_re) begin
            cur_rd_reg     <= cur_mem[cur_raddr];
            cur_rd_vld_reg <= vld_reg[cur_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (src_we) begin
            src_mem[copy_pos_reg] <= cur_rd_word;
        end
        if (st_re) begin
            src_rd_reg <= src_mem[idx_reg[LED_IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (tgt_we) begin
            tgt_mem[pos_reg[LED_IDX_W-1:0]] <= s_data.colour_word;
        end
        if (st_re) begin
            tgt_rd_reg <= tgt_mem[idx_reg[LED_IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            num_leds_reg  <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            done_reg      <= '0;
            copy_en_reg   <= 1'b0;
            last_reg      <= 1'b0;
            vld_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            num_leds_reg  <= num_leds_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            done_reg      <= done_next;
            copy_en_reg   <= copy_en_next;
            last_reg      <= last_next;
            vld_reg       <= vld_next;
            m_valid_reg   <= m_valid_next;
        end
        portion_reg  <= portion_next;
        copy_pos_reg <= copy_pos_next;
        cycles_reg   <= cycles_next;
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : led_string_fade_engine
`default_nettype wire
